@@ rtl/m5f_pkg.sv @@
package m5f_pkg;

    localparam int unsigned NUM_SAMPLES = 5;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned TOL_W       = 16;
    localparam int unsigned WEIGHT_W    = 17;
    localparam int unsigned CFG_IDX_W   = 1;
    // sort key: pad flag above the sample with its sign bit flipped
    localparam int unsigned KEY_W       = SAMPLE_W + 1;
    localparam int unsigned NUM_CMP     = 9;

    // five-input sorting network, comparators in dependency order
    localparam int unsigned CMP_LO [NUM_CMP] = '{0, 3, 2, 2, 1, 0, 0, 1, 1};
    localparam int unsigned CMP_HI [NUM_CMP] = '{1, 4, 4, 3, 4, 3, 2, 3, 2};

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_TOL     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 1'b1;

    localparam logic [TOL_W-1:0]    TOL_RESET    = '0;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'h10000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [NUM_SAMPLES-1:0][KEY_W-1:0] key_vec_t;
    typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_vec_t;

    typedef struct packed {
        logic    load;
        logic    use_median;
        sample_t median;
    } ema_req_t;

endpackage

@@ rtl/m5f_sorter.sv @@
module m5f_sorter
    import m5f_pkg::*;
(
    input  key_vec_t keys,
    output key_vec_t sorted
);

    key_vec_t net [NUM_CMP+1];

    assign net[0] = keys;

    for (genvar k = 0; k < NUM_CMP; k++) begin : g_cmp
        always_comb
        begin
            net[k+1] = net[k];
            if (net[k][CMP_LO[k]] > net[k][CMP_HI[k]])
            begin
                net[k+1][CMP_LO[k]] = net[k][CMP_HI[k]];
                net[k+1][CMP_HI[k]] = net[k][CMP_LO[k]];
            end
        end
    end

    assign sorted = net[NUM_CMP];

endmodule

@@ rtl/m5f_ema.sv @@
module m5f_ema
    import m5f_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ema_req_t            req,
    input  logic [WEIGHT_W-1:0] weight,
    output sample_t             ema_value,
    output sample_t             ema_upd
);

    sample_t                      ema_reg;
    sample_t                      ema_next;
    logic signed [SAMPLE_W:0]     diff;
    logic signed [2*SAMPLE_W+1:0] prod;
    logic signed [SAMPLE_W+1:0]   sum;
    sample_t                      blended;

    // old + floor(w * (median - old) / 2^16)
    always_comb
    begin
        diff = {req.median[SAMPLE_W-1], req.median} - {ema_reg[SAMPLE_W-1], ema_reg};
        prod = $signed({1'b0, weight[WEIGHT_W-2:0]}) * diff;
        sum  = {{2{ema_reg[SAMPLE_W-1]}}, ema_reg} + prod[2*SAMPLE_W+1:SAMPLE_W];
        if (weight[WEIGHT_W-1])
            blended = req.median;
        else
            blended = sum[SAMPLE_W-1:0];
        ema_upd  = req.use_median ? blended : ema_reg;
        ema_next = req.load ? ema_upd : ema_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ema_reg <= '0;
        else
            ema_reg <= ema_next;
    end

    assign ema_value = ema_reg;

endmodule

@@ rtl/median5_outlier_ema_filter.sv @@
// median5_outlier_ema_filter
// pipeline: an accepted request passes through the input, median and result
// registers in turn; one request per cycle while out_ready does not stall, set by the
// average update loop through one 17x17 multiplier
// reset: empty pipeline, tolerance 0, weight 1.0, moving average 0
module median5_outlier_ema_filter
    import m5f_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sample_t              sample_0,
    input  sample_t              sample_1,
    input  sample_t              sample_2,
    input  sample_t              sample_3,
    input  sample_t              sample_4,
    input  logic [COUNT_W-1:0]   sample_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sample_t              smoothed,
    output sample_t              median_value,
    output logic [SAMPLE_W-1:0]  spread,
    output logic                 outlier,
    output logic                 valid_res
);

    logic [TOL_W-1:0]    tol_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    logic                in_v_reg;
    sample_vec_t         samp_reg;
    logic [COUNT_W-1:0]  cnt_reg;

    logic                mid_v_reg;
    sample_t             med_reg;
    logic [SAMPLE_W-1:0] spr_reg;
    logic                flag_reg;
    logic                vres_reg;

    logic                out_v_reg;
    sample_t             smooth_reg;
    sample_t             omed_reg;
    logic [SAMPLE_W-1:0] ospr_reg;
    logic                oflag_reg;
    logic                ovres_reg;

    logic                out_room;
    logic                mid_room;
    logic                mid_move;
    logic                in_move;

    logic [COUNT_W-1:0]  usable;
    key_vec_t            keys;
    key_vec_t            sorted;
    key_t                med_key;
    key_t                max_key;
    sample_t             med_val;
    sample_t             min_val;
    sample_t             max_val;
    logic [SAMPLE_W:0]   spr_full;
    sample_t             med_next;
    logic [SAMPLE_W-1:0] spr_next;
    logic                flag_next;
    logic                vres_next;

    ema_req_t            ema_req;
    sample_t             ema_value;
    sample_t             ema_upd;

    // pipeline flow control
    assign out_room = !out_v_reg || out_ready;
    assign mid_room = !mid_v_reg || out_room;
    assign mid_move = mid_v_reg && out_room;
    assign in_ready = !in_v_reg || mid_room;
    assign in_move  = in_v_reg && mid_room;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NOISE_TOL:     tol_reg    <= cfg_data[TOL_W-1:0];
                REG_SMOOTH_WEIGHT: weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_v_reg <= in_valid;
            if (mid_room)
                mid_v_reg <= in_v_reg;
            if (out_room)
                out_v_reg <= mid_v_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            samp_reg <= {sample_4, sample_3, sample_2, sample_1, sample_0};
            cnt_reg  <= sample_count;
        end
    end

    // counts above five use all five samples; unused slots sort to the top
    always_comb
    begin
        usable = (cnt_reg > COUNT_W'(NUM_SAMPLES)) ? COUNT_W'(NUM_SAMPLES) : cnt_reg;
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            keys[i] = {(COUNT_W'(i) >= usable), ~samp_reg[i][SAMPLE_W-1],
                       samp_reg[i][SAMPLE_W-2:0]};
        end
    end

    m5f_sorter u_sorter (
        .keys   (keys),
        .sorted (sorted)
    );

    always_comb
    begin
        case (usable)
            3'd1:    begin med_key = sorted[0]; max_key = sorted[0]; end
            3'd2:    begin med_key = sorted[1]; max_key = sorted[1]; end
            3'd3:    begin med_key = sorted[1]; max_key = sorted[2]; end
            3'd4:    begin med_key = sorted[2]; max_key = sorted[3]; end
            default: begin med_key = sorted[2]; max_key = sorted[4]; end
        endcase
        med_val  = {~med_key[SAMPLE_W-1], med_key[SAMPLE_W-2:0]};
        max_val  = {~max_key[SAMPLE_W-1], max_key[SAMPLE_W-2:0]};
        min_val  = {~sorted[0][SAMPLE_W-1], sorted[0][SAMPLE_W-2:0]};
        spr_full = {max_val[SAMPLE_W-1], max_val} - {min_val[SAMPLE_W-1], min_val};

        vres_next = (usable != '0);
        med_next  = vres_next ? med_val : '0;
        spr_next  = vres_next ? spr_full[SAMPLE_W-1:0] : '0;
        flag_next = vres_next && (tol_reg != '0) && (spr_full[SAMPLE_W-1:0] > tol_reg);
    end

    // median register
    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            med_reg  <= med_next;
            spr_reg  <= spr_next;
            flag_reg <= flag_next;
            vres_reg <= vres_next;
        end
    end

    assign ema_req.load       = mid_move;
    assign ema_req.use_median = vres_reg;
    assign ema_req.median     = med_reg;

    m5f_ema u_ema (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (ema_req),
        .weight    (weight_reg),
        .ema_value (ema_value),
        .ema_upd   (ema_upd)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (mid_move)
        begin
            smooth_reg <= ema_upd;
            omed_reg   <= med_reg;
            ospr_reg   <= spr_reg;
            oflag_reg  <= flag_reg;
            ovres_reg  <= vres_reg;
        end
    end

    assign out_valid    = out_v_reg;
    assign smoothed     = smooth_reg;
    assign median_value = omed_reg;
    assign spread       = ospr_reg;
    assign outlier      = oflag_reg;
    assign valid_res    = ovres_reg;

    // the average moves only when a request leaves the median stage
    a_ema_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !mid_move |=> $stable(ema_value))
        else $error("moving average changed without a request");

    // an invalid result carries zero median, spread and flag
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (median_value == '0 && spread == '0 && !outlier))
        else $error("invalid result with nonzero fields");

    // a flagged result has a nonzero spread and usable samples
    a_flag_spread: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_v_reg && flag_reg) |-> (spr_reg != '0 && vres_reg))
        else $error("outlier flag without spread");

    // the result shows the average that the update left behind
    a_smooth_match: assert property (@(posedge clk) disable iff (!rst_n)
        mid_move |=> (smoothed == ema_value))
        else $error("result does not match stored average");

endmodule

@@ tb/ema_filter_checker.sv @@
module ema_filter_checker
    import m5f_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]  cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  sample_t              sample_0,
    input  sample_t              sample_1,
    input  sample_t              sample_2,
    input  sample_t              sample_3,
    input  sample_t              sample_4,
    input  logic [COUNT_W-1:0]   sample_count,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  sample_t              smoothed,
    input  sample_t              median_value,
    input  logic [SAMPLE_W-1:0]  spread,
    input  logic                 outlier,
    input  logic                 valid_res,
    output int                   mismatches,
    output int                   pending,
    output int                   results_seen,
    output int                   outliers_seen,
    output int                   empty_seen
);

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam int MAX_REPORTS = 30;

    typedef struct {
        sample_t             smoothed;
        sample_t             median;
        logic [SAMPLE_W-1:0] spread;
        logic                outlier;
        logic                valid;
    } filter_result_t;

    filter_result_t      expected_results[$];
    logic [TOL_W-1:0]    tolerance;
    logic [WEIGHT_W-1:0] weight;
    sample_t             average;
    int                  reports;

    function automatic sample_t blend_average(sample_t old_avg, sample_t med,
                                              logic [WEIGHT_W-1:0] w);
        longint acc;
        if (w == 0)
            return old_avg;
        if (w >= WEIGHT_ONE)
            return med;
        acc = longint'(w) * longint'(med) + longint'(65536 - w) * longint'(old_avg);
        // arithmetic shift floors toward minus infinity
        return sample_t'(acc >>> 16);
    endfunction

    function automatic filter_result_t filter_samples(sample_t s [NUM_SAMPLES],
                                                      logic [COUNT_W-1:0] cnt,
                                                      sample_t cur_avg);
        filter_result_t r;
        sample_t        sorted [NUM_SAMPLES];
        sample_t        key;
        int             used;
        int             j;
        used = (cnt > NUM_SAMPLES) ? NUM_SAMPLES : cnt;
        r.smoothed = cur_avg;
        r.median   = '0;
        r.spread   = '0;
        r.outlier  = 1'b0;
        r.valid    = 1'b0;
        if (used == 0)
            return r;
        sorted = s;
        for (int i = 1; i < used; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        // upper median for even counts
        r.median   = sorted[used / 2];
        r.spread   = sorted[used-1] - sorted[0];
        r.outlier  = (tolerance != 0) && (r.spread > tolerance);
        r.valid    = 1'b1;
        r.smoothed = blend_average(cur_avg, r.median, weight);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            else if (reports == MAX_REPORTS)
                $display("%0t: further mismatches not shown", $time);
            reports++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t want;
        sample_t        s [NUM_SAMPLES];
        if (!rst_n)
        begin
            expected_results.delete();
            tolerance     = TOL_RESET;
            weight        = WEIGHT_RESET;
            average       = '0;
            mismatches    = 0;
            reports       = 0;
            results_seen  = 0;
            outliers_seen = 0;
            empty_seen    = 0;
            pending      <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (outlier === 1'b1)
                    outliers_seen++;
                if (valid_res === 1'b0)
                    empty_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, smoothed %0d",
                             $time, smoothed);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("smoothed", want.smoothed, smoothed);
                    check_field("median_value", want.median, median_value);
                    check_field("spread", want.spread, spread);
                    check_field("outlier", want.outlier, outlier);
                    check_field("valid_res", want.valid, valid_res);
                end
            end
            if (in_valid && in_ready)
            begin
                s = '{sample_0, sample_1, sample_2, sample_3, sample_4};
                want = filter_samples(s, sample_count, average);
                average = want.smoothed;
                expected_results.push_back(want);
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_NOISE_TOL)
                    tolerance = cfg_data[TOL_W-1:0];
                else if (cfg_index == REG_SMOOTH_WEIGHT)
                    weight = cfg_data;
            end
            pending <= expected_results.size();
        end
    end

endmodule

@@ tb/tb_median5_outlier_ema_filter.sv @@
module tb_median5_outlier_ema_filter;
    import m5f_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 200;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 85;

    localparam sample_t EDGE_VALUES [5] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                                            16'shFFFF, 16'sh0001};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NOISE_TOL;
    logic [WEIGHT_W-1:0]  cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    sample_t              sample_0 = '0;
    sample_t              sample_1 = '0;
    sample_t              sample_2 = '0;
    sample_t              sample_3 = '0;
    sample_t              sample_4 = '0;
    logic [COUNT_W-1:0]   sample_count = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    sample_t              smoothed;
    sample_t              median_value;
    logic [SAMPLE_W-1:0]  spread;
    logic                 outlier;
    logic                 valid_res;

    int mismatches;
    int pending;
    int results_seen;
    int outliers_seen;
    int empty_seen;

    int  requests_sent = 0;
    int  settings_loaded = 0;
    bit  tx_no_gaps = 1'b0;
    bit  rx_always_ready = 1'b0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  rx_stall_left = 0;
    int  rx_roll;
    int  idle_cycles = 0;

    median5_outlier_ema_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_0     (sample_0),
        .sample_1     (sample_1),
        .sample_2     (sample_2),
        .sample_3     (sample_3),
        .sample_4     (sample_4),
        .sample_count (sample_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .smoothed     (smoothed),
        .median_value (median_value),
        .spread       (spread),
        .outlier      (outlier),
        .valid_res    (valid_res)
    );

    ema_filter_checker filter_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_0      (sample_0),
        .sample_1      (sample_1),
        .sample_2      (sample_2),
        .sample_3      (sample_3),
        .sample_4      (sample_4),
        .sample_count  (sample_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .smoothed      (smoothed),
        .median_value  (median_value),
        .spread        (spread),
        .outlier       (outlier),
        .valid_res     (valid_res),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .outliers_seen (outliers_seen),
        .empty_seen    (empty_seen)
    );

    always #1 clk = ~clk;

    // result side: random stalls, plus a long hold when the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            rx_stall_left = LONG_HOLD;
        end
        if (rx_stall_left > 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_always_ready)
            out_ready <= 1'b1;
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 60)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                rx_stall_left = (rx_roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (tx_no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_samples(input sample_t s [NUM_SAMPLES], input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_0     <= s[0];
        sample_1     <= s[1];
        sample_2     <= s[2];
        sample_3     <= s[3];
        sample_4     <= s[4];
        sample_count <= cnt;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        // let the outstanding count take in the last accepted request
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [WEIGHT_W-1:0] tol_data,
                               input logic [WEIGHT_W-1:0] weight_data);
        cfg_write <= 1'b1;
        cfg_index <= REG_NOISE_TOL;
        cfg_data  <= tol_data;
        @(posedge clk);
        cfg_index <= REG_SMOOTH_WEIGHT;
        cfg_data  <= weight_data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_loaded++;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_tolerance();
        int roll;
        logic [TOL_W-1:0] tol;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            tol = TOL_W'($urandom_range(1, 512));
        else
            tol = TOL_W'($urandom_range(0, 65535));
        // upper data bit is not part of the tolerance register
        return {1'($urandom_range(0, 1)), tol};
    endfunction

    task automatic send_random_item();
        sample_t            s [NUM_SAMPLES];
        sample_t            center;
        logic [COUNT_W-1:0] cnt;
        int                 roll;
        int                 style;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            cnt = '0;
        else if (roll < 10)
            cnt = COUNT_W'($urandom_range(6, 7));
        else
            cnt = COUNT_W'($urandom_range(1, 5));
        style  = $urandom_range(0, 9);
        center = sample_t'($urandom_range(0, 65535));
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            if (style < 4)
                s[i] = sample_t'($urandom);
            else if (style < 8)
                s[i] = sample_t'(center + $urandom_range(0, 511) - 256);
            else if (style == 8)
                s[i] = EDGE_VALUES[$urandom_range(0, 4)];
            else
                s[i] = center;
        end
        send_samples(s, cnt);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!rst_n);

        // reset settings: no outlier check, average follows the median
        send_samples('{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001}, 3'd0);
        send_samples('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 3'd1);
        send_samples('{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 3'd1);
        send_samples('{16'sd5, -16'sd5, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 3'd2);
        send_samples('{16'sd300, -16'sd200, 16'sd100, 16'sh8000, 16'sh8000}, 3'd3);
        send_samples('{-16'sd1, 16'sd4, 16'sd2, 16'sd3, 16'sh7FFF}, 3'd4);
        send_samples('{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001}, 3'd5);
        send_samples('{-16'sd7, -16'sd7, -16'sd7, -16'sd7, -16'sd7}, 3'd5);
        // counts past five saturate
        send_samples('{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5}, 3'd6);
        send_samples('{16'sd50, 16'sd40, 16'sd30, 16'sd20, 16'sd10}, 3'd7);
        send_samples('{16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9}, 3'd0);
        send_samples('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 3'd5);
        wait_until_drained();

        // tolerance of one, average frozen
        load_config(17'h10001, 17'h00000);
        send_samples('{16'sd10, 16'sd11, 16'sd0, 16'sd0, 16'sd0}, 3'd2);
        send_samples('{16'sd10, 16'sd12, 16'sd0, 16'sd0, 16'sd0}, 3'd2);
        send_samples('{16'sd3, 16'sd3, 16'sd3, 16'sd3, 16'sd3}, 3'd0);
        wait_until_drained();

        load_config(17'h0FFFF, 17'h08000);
        send_samples('{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001}, 3'd5);
        send_samples('{16'sh8000, 16'sh8000, 16'sh8001, 16'sd0, 16'sd0}, 3'd3);
        send_samples('{16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 16'sd0}, 3'd4);
        wait_until_drained();

        load_config(17'h08000, 17'h00001);
        send_samples('{16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 3'd5);
        send_samples('{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 3'd2);
        send_samples('{16'sh8000, 16'sd1, 16'sd0, 16'sd0, 16'sd0}, 3'd2);
        wait_until_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: load_config(pick_tolerance(), WEIGHT_W'($urandom_range(1, 65535)));
                1: load_config(17'h00000, 17'h10000);
                2: load_config(17'h0FFFF, 17'h1FFFF);
                3: load_config(17'h00001, 17'h10001);
                4: load_config(pick_tolerance(), 17'h00000);
                5: load_config(pick_tolerance(), 17'h00001);
                6: load_config(pick_tolerance(), 17'h0FFFF);
                default: load_config(pick_tolerance(),
                                     WEIGHT_W'($urandom_range(0, 17'h1FFFF)));
            endcase
            // one stretch with no idling at all
            tx_no_gaps = (phase == 1);
            rx_always_ready <= (phase == 1);
            if (phase == 2)
            begin
                // result side holds off while requests keep coming
                hold_requests <= hold_requests + 1;
                tx_no_gaps = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 2 && n == 30)
                    tx_no_gaps = 1'b0;
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    wait_until_drained();
                send_random_item();
            end
            wait_until_drained();
        end
        tx_no_gaps = 1'b0;
        rx_always_ready <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d requests under %0d register settings", requests_sent, settings_loaded);
        $display("checked %0d results: %0d outliers flagged, %0d with no usable samples",
                 results_seen, outliers_seen, empty_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
